// ===== sv/tdd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the tile dirty detector: field widths, register codes,
// reset values, default sizes and the result type. No dependencies.
package tdd_pkg;

   localparam int unsigned TILE_EDGE_DEF  = 16;
   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned MAX_HEIGHT_DEF = 512;

   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned TILE_IDX_W  = 11;
   localparam int unsigned COUNT_W     = 12;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned FWIDTH_W    = 11;
   localparam int unsigned FHEIGHT_W   = 10;
   localparam int unsigned HUDROW_W    = 10;

   localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST   = 11'd320;
   localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST  = 10'd200;
   localparam logic [HUDROW_W-1:0]  HUD_START_ROW_RST = 10'd168;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH   = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_HUD_START_ROW = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TILE_IDX_W-1:0] tile_index;
      logic                  tile_dirty;
      logic                  tile_is_hud;
      logic                  frame_done;
      logic [COUNT_W-1:0]    dirty_tile_count;
      logic [COUNT_W-1:0]    clean_tile_count;
      logic [COUNT_W-1:0]    hud_dirty_count;
      logic [COUNT_W-1:0]    hud_clean_count;
      logic                  hud_unchanged;
   } rsp_type;

endpackage

// ===== sv/tdd_if.sv =====
`timescale 1ns / 1ps
// Handshake interfaces of the tile dirty detector: pixel requests, tile
// results and register writes. Depends on tdd_pkg.
interface tdd_req_if;
   import tdd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PIXEL_W-1:0]   pixel_value;
   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface tdd_rsp_if;
   import tdd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [TILE_IDX_W-1:0] tile_index;
   logic                  tile_dirty;
   logic                  tile_is_hud;
   logic                  frame_done;
   logic [COUNT_W-1:0]    dirty_tile_count;
   logic [COUNT_W-1:0]    clean_tile_count;
   logic [COUNT_W-1:0]    hud_dirty_count;
   logic [COUNT_W-1:0]    hud_clean_count;
   logic                  hud_unchanged;
   modport source (output valid, output tile_index, output tile_dirty, output tile_is_hud,
                   output frame_done, output dirty_tile_count, output clean_tile_count,
                   output hud_dirty_count, output hud_clean_count, output hud_unchanged,
                   input ready);
   modport sink   (input valid, input tile_index, input tile_dirty, input tile_is_hud,
                   input frame_done, input dirty_tile_count, input clean_tile_count,
                   input hud_dirty_count, input hud_clean_count, input hud_unchanged,
                   output ready);
endinterface

interface tdd_csr_if;
   import tdd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/tile_dirty_detector_top.sv =====
`timescale 1ns / 1ps
// A tile result is offered from the result queue after the compare stage registers it.
// Throughput: one pixel request per cycle while the result queue has room, set by the
// frame memory's read and write each cycle; a four-entry queue absorbs output stalls.
// Reset: synchronous; positions, column flags and totals clear and the next frame is
// treated as a first frame. The stored frame is not cleared and needs no clearing pass.
module tile_dirty_detector_top #(
   parameter int unsigned TILE_EDGE  = tdd_pkg::TILE_EDGE_DEF,
   parameter int unsigned MAX_WIDTH  = tdd_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = tdd_pkg::MAX_HEIGHT_DEF
) (
   input  logic     clock,
   input  logic     reset,
   tdd_req_if.sink  req_ch,
   tdd_rsp_if.source rsp_ch,
   tdd_csr_if.sink  csr_ch
);
   import tdd_pkg::*;

   localparam int unsigned COL_TILES  = (MAX_WIDTH + TILE_EDGE - 1) / TILE_EDGE;
   localparam int unsigned ROW_TILES  = (MAX_HEIGHT + TILE_EDGE - 1) / TILE_EDGE;
   localparam int unsigned NUM_TILES  = COL_TILES * ROW_TILES;
   localparam int unsigned MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned CW   = $clog2(MAX_WIDTH);
   localparam int unsigned RW   = $clog2(MAX_HEIGHT);
   localparam int unsigned SW   = $clog2(TILE_EDGE);
   localparam int unsigned TCW  = (COL_TILES > 1) ? $clog2(COL_TILES) : 1;
   localparam int unsigned TIW  = (NUM_TILES > 1) ? $clog2(NUM_TILES) : 1;
   localparam int unsigned AW   = $clog2(MEM_DEPTH);
   localparam int unsigned TOT_W = ($clog2(NUM_TILES + 1) > COUNT_W) ?
                                   $clog2(NUM_TILES + 1) : COUNT_W;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FPW  = $clog2(FIFO_DEPTH);

   logic [FWIDTH_W-1:0]  frame_width_ff;
   logic [FHEIGHT_W-1:0] frame_height_ff;
   logic [HUDROW_W-1:0]  hud_start_row_ff;
   logic                 csr_fire;
   logic                 csr_known;
   logic                 csr_size;

   logic [CW-1:0]  w_last;
   logic [RW-1:0]  h_last;

   logic [CW-1:0]  col_ff;
   logic [RW-1:0]  row_ff;
   logic [SW-1:0]  sub_col_ff;
   logic [SW-1:0]  sub_row_ff;
   logic [TCW-1:0] tcol_ff;
   logic [RW-1:0]  tile_row_start_ff;
   logic [TIW-1:0] tile_base_ff;
   logic [AW-1:0]  row_base_ff;

   logic           req_fire;
   logic           last_col;
   logic           last_row;
   logic           sub_col_end;
   logic           sub_row_end;
   logic [AW-1:0]  rd_addr;

   logic [PIXEL_W-1:0] frame_mem [MEM_DEPTH];
   logic [PIXEL_W-1:0] mem_rd_ff;

   logic               s1_valid_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic [TCW-1:0]     s1_tcol_ff;
   logic               s1_tile_end_ff;
   logic               s1_done_ff;
   logic [TIW-1:0]     s1_idx_ff;
   logic               s1_hud_ff;
   logic               s1_fwd_hit_ff;
   logic [PIXEL_W-1:0] s1_fwd_data_ff;

   logic               first_ff;
   logic [COL_TILES-1:0] col_flag_ff;
   logic [TOT_W-1:0]   dirty_tot_ff;
   logic [TOT_W-1:0]   clean_tot_ff;
   logic [TOT_W-1:0]   hud_dirty_tot_ff;
   logic [TOT_W-1:0]   hud_clean_tot_ff;
   logic [TOT_W-1:0]   dirty_tot_in;
   logic [TOT_W-1:0]   clean_tot_in;
   logic [TOT_W-1:0]   hud_dirty_tot_in;
   logic [TOT_W-1:0]   hud_clean_tot_in;

   logic [PIXEL_W-1:0] prev_pix;
   logic               changed;
   logic               mem_we;
   logic               flag_now;
   logic               tile_dirty;
   logic               push;
   logic               pop;
   rsp_type            push_data;

   rsp_type            fifo_ff [FIFO_DEPTH];
   logic [FPW-1:0]     wr_ptr_ff;
   logic [FPW-1:0]     rd_ptr_ff;
   logic [FPW:0]       fifo_cnt_ff;
   rsp_type            head;

   // Register port.
   assign csr_ch.ready = 1'b1;
   assign csr_fire  = csr_ch.valid && csr_ch.ready;
   assign csr_known = (csr_ch.index == CSR_FRAME_WIDTH) ||
                      (csr_ch.index == CSR_FRAME_HEIGHT) ||
                      (csr_ch.index == CSR_HUD_START_ROW);
   assign csr_size  = (csr_ch.index == CSR_FRAME_WIDTH) ||
                      (csr_ch.index == CSR_FRAME_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RST;
         frame_height_ff  <= FRAME_HEIGHT_RST;
         hud_start_row_ff <= HUD_START_ROW_RST;
      end else if (csr_fire) begin
         case (csr_ch.index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_ch.data;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_ch.data[FHEIGHT_W-1:0];
            end
            CSR_HUD_START_ROW: begin
               hud_start_row_ff <= csr_ch.data[HUDROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sizes saturated to the stored frame's limits, as last positions.
   always_comb begin
      if (frame_width_ff == '0) begin
         w_last = '0;
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_last = CW'(MAX_WIDTH - 1);
      end else begin
         w_last = CW'(frame_width_ff - 1'b1);
      end
      if (frame_height_ff == '0) begin
         h_last = '0;
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_last = RW'(MAX_HEIGHT - 1);
      end else begin
         h_last = RW'(frame_height_ff - 1'b1);
      end
   end

   // Request stage: raster position, tile position and memory read.
   assign req_ch.ready = (32'(fifo_cnt_ff) + 32'(s1_valid_ff)) < FIFO_DEPTH;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign last_col     = (col_ff == w_last);
   assign last_row     = (row_ff == h_last);
   assign sub_col_end  = (sub_col_ff == SW'(TILE_EDGE - 1));
   assign sub_row_end  = (sub_row_ff == SW'(TILE_EDGE - 1));
   assign rd_addr      = AW'(row_base_ff + AW'(col_ff));

   always_ff @(posedge clock) begin
      if (reset || (csr_fire && csr_known)) begin
         col_ff            <= '0;
         row_ff            <= '0;
         sub_col_ff        <= '0;
         sub_row_ff        <= '0;
         tcol_ff           <= '0;
         tile_row_start_ff <= '0;
         tile_base_ff      <= '0;
         row_base_ff       <= '0;
      end else if (req_fire) begin
         if (last_col) begin
            col_ff     <= '0;
            sub_col_ff <= '0;
            tcol_ff    <= '0;
            if (last_row) begin
               row_ff            <= '0;
               sub_row_ff        <= '0;
               tile_row_start_ff <= '0;
               tile_base_ff      <= '0;
               row_base_ff       <= '0;
            end else begin
               row_ff      <= RW'(row_ff + 1'b1);
               row_base_ff <= AW'(row_base_ff + AW'(MAX_WIDTH));
               if (sub_row_end) begin
                  sub_row_ff        <= '0;
                  tile_row_start_ff <= RW'(tile_row_start_ff + RW'(TILE_EDGE));
                  tile_base_ff      <= TIW'(tile_base_ff + TIW'(tcol_ff) + 1'b1);
               end else begin
                  sub_row_ff <= SW'(sub_row_ff + 1'b1);
               end
            end
         end else begin
            col_ff <= CW'(col_ff + 1'b1);
            if (sub_col_end) begin
               sub_col_ff <= '0;
               tcol_ff    <= TCW'(tcol_ff + 1'b1);
            end else begin
               sub_col_ff <= SW'(sub_col_ff + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[s1_addr_ff] <= s1_pix_ff;
      end
      if (req_fire) begin
         mem_rd_ff <= frame_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_addr_ff     <= rd_addr;
         s1_pix_ff      <= req_ch.pixel_value;
         s1_tcol_ff     <= tcol_ff;
         s1_tile_end_ff <= (last_col || sub_col_end) && (last_row || sub_row_end);
         s1_done_ff     <= last_col && last_row;
         s1_idx_ff      <= TIW'(tile_base_ff + TIW'(tcol_ff));
         s1_hud_ff      <= 32'(tile_row_start_ff) >= 32'(hud_start_row_ff);
         s1_fwd_hit_ff  <= mem_we && (s1_addr_ff == rd_addr);
         s1_fwd_data_ff <= s1_pix_ff;
      end
   end

   // Compare stage: the write of the previous pixel is forwarded when it hits the
   // same entry that this pixel read in the same cycle.
   assign prev_pix   = s1_fwd_hit_ff ? s1_fwd_data_ff : mem_rd_ff;
   assign changed    = first_ff || (prev_pix != s1_pix_ff);
   assign mem_we     = s1_valid_ff && changed;
   assign flag_now   = col_flag_ff[s1_tcol_ff] || changed;
   assign tile_dirty = flag_now || first_ff;

   always_comb begin
      dirty_tot_in     = dirty_tot_ff;
      clean_tot_in     = clean_tot_ff;
      hud_dirty_tot_in = hud_dirty_tot_ff;
      hud_clean_tot_in = hud_clean_tot_ff;
      if (tile_dirty) begin
         dirty_tot_in = TOT_W'(dirty_tot_ff + 1'b1);
         if (s1_hud_ff) begin
            hud_dirty_tot_in = TOT_W'(hud_dirty_tot_ff + 1'b1);
         end
      end else begin
         clean_tot_in = TOT_W'(clean_tot_ff + 1'b1);
         if (s1_hud_ff) begin
            hud_clean_tot_in = TOT_W'(hud_clean_tot_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff         <= 1'b1;
         col_flag_ff      <= '0;
         dirty_tot_ff     <= '0;
         clean_tot_ff     <= '0;
         hud_dirty_tot_ff <= '0;
         hud_clean_tot_ff <= '0;
      end else if (csr_fire && csr_known) begin
         if (csr_size) begin
            first_ff <= 1'b1;
         end
         col_flag_ff      <= '0;
         dirty_tot_ff     <= '0;
         clean_tot_ff     <= '0;
         hud_dirty_tot_ff <= '0;
         hud_clean_tot_ff <= '0;
      end else if (s1_valid_ff) begin
         if (s1_tile_end_ff && s1_done_ff) begin
            first_ff         <= 1'b0;
            col_flag_ff      <= '0;
            dirty_tot_ff     <= '0;
            clean_tot_ff     <= '0;
            hud_dirty_tot_ff <= '0;
            hud_clean_tot_ff <= '0;
         end else if (s1_tile_end_ff) begin
            col_flag_ff[s1_tcol_ff] <= 1'b0;
            dirty_tot_ff     <= dirty_tot_in;
            clean_tot_ff     <= clean_tot_in;
            hud_dirty_tot_ff <= hud_dirty_tot_in;
            hud_clean_tot_ff <= hud_clean_tot_in;
         end else begin
            col_flag_ff[s1_tcol_ff] <= flag_now;
         end
      end
   end

   // Result queue.
   always_comb begin
      push_data = '0;
      push_data.tile_index  = TILE_IDX_W'(s1_idx_ff);
      push_data.tile_dirty  = tile_dirty;
      push_data.tile_is_hud = s1_hud_ff;
      if (s1_done_ff) begin
         push_data.frame_done       = 1'b1;
         push_data.dirty_tile_count = COUNT_W'(dirty_tot_in);
         push_data.clean_tile_count = COUNT_W'(clean_tot_in);
         push_data.hud_dirty_count  = COUNT_W'(hud_dirty_tot_in);
         push_data.hud_clean_count  = COUNT_W'(hud_clean_tot_in);
         push_data.hud_unchanged    = (hud_dirty_tot_in == '0);
      end
   end

   assign push = s1_valid_ff && s1_tile_end_ff;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= FPW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= FPW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            fifo_cnt_ff <= (FPW + 1)'(fifo_cnt_ff + 1'b1);
         end else if (pop && !push) begin
            fifo_cnt_ff <= (FPW + 1)'(fifo_cnt_ff - 1'b1);
         end
      end
   end

   assign head                    = fifo_ff[rd_ptr_ff];
   assign rsp_ch.valid            = (fifo_cnt_ff != '0);
   assign rsp_ch.tile_index       = head.tile_index;
   assign rsp_ch.tile_dirty       = head.tile_dirty;
   assign rsp_ch.tile_is_hud      = head.tile_is_hud;
   assign rsp_ch.frame_done       = head.frame_done;
   assign rsp_ch.dirty_tile_count = head.dirty_tile_count;
   assign rsp_ch.clean_tile_count = head.clean_tile_count;
   assign rsp_ch.hud_dirty_count  = head.hud_dirty_count;
   assign rsp_ch.hud_clean_count  = head.hud_clean_count;
   assign rsp_ch.hud_unchanged    = head.hud_unchanged;

`ifndef SYNTH
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fifo_cnt_ff) <= FIFO_DEPTH)
      else $error("result queue count beyond its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (32'(fifo_cnt_ff) < FIFO_DEPTH) || pop)
      else $error("result pushed into a full queue");

   a_first_frame_ends: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_tile_end_ff && s1_done_ff) |=> !first_ff)
      else $error("first frame flag still set after a completed frame");
`endif

endmodule
